/* design/queue_with_key_delete_top_macros.svh */
// ----------------------------------------------------------------------------
// queue_with_key_delete_top_macros
// assertion macros used by the queue top design file
// ----------------------------------------------------------------------------
`ifndef QUEUE_WITH_KEY_DELETE_TOP_MACROS_SVH
`define QUEUE_WITH_KEY_DELETE_TOP_MACROS_SVH

// same-cycle implication under reset
`define QWKD_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication under reset
`define QWKD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* design/qwkd_pkg.sv */
// ----------------------------------------------------------------------------
// qwkd_pkg
// shared types and constants of the ordered queue with key delete
// ----------------------------------------------------------------------------
package qwkd_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int IN_WIDTH       = 32;
   localparam int OCC_WIDTH      = 5;
   localparam int OP_WIDTH       = 2;
   localparam int STATUS_WIDTH   = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_APPEND = 2'd0,
      OP_HEAD   = 2'd1,
      OP_KEY    = 2'd2,
      OP_TAIL   = 2'd3
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STS_OK       = 2'd0,
      STS_EMPTY    = 2'd1,
      STS_NOTFOUND = 2'd2,
      STS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic   mark;
      logic   apply;
      op_type op;
   } cell_ctl_type;

endpackage

/* design/qwkd_cell.sv */
// ----------------------------------------------------------------------------
// qwkd_cell
// one queue slot: holds a word, marks itself for removal, shifts from its
// right neighbor and passes the found flag to the right
// ----------------------------------------------------------------------------
module qwkd_cell #(
   parameter int DATA_WIDTH = qwkd_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qwkd_pkg::cell_ctl_type ctl,
   input  logic [DATA_WIDTH-1:0] word,
   input  logic                  prev_valid,
   input  logic                  found_in,
   input  logic                  next_valid,
   input  logic [DATA_WIDTH-1:0] next_data,
   output logic                  valid,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  found_out,
   output logic [DATA_WIDTH-1:0] pick
);
   import qwkd_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  kill_ff;
   logic                  kill_in;
   logic                  first;

   assign found_out = found_in | kill_ff;
   assign first     = kill_ff & ~found_in;
   assign pick      = first ? data_ff : '0;
   assign valid     = valid_ff;
   assign data      = data_ff;

   always_comb begin
      kill_in  = kill_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.mark) begin
         case (ctl.op)
            OP_HEAD: kill_in = valid_ff;
            OP_TAIL: kill_in = valid_ff & ~next_valid;
            OP_KEY:  kill_in = valid_ff & (data_ff == word);
            default: kill_in = 1'b0;
         endcase
      end
      if (ctl.apply) begin
         kill_in = 1'b0;
         if (ctl.op == OP_APPEND) begin
            // first free slot takes the word
            if (!valid_ff && prev_valid) begin
               valid_in = 1'b1;
               data_in  = word;
            end
         end else if (found_out) begin
            valid_in = next_valid;
            data_in  = next_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         kill_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         kill_ff  <= kill_in;
      end
      data_ff <= data_in;
   end

endmodule

/* design/queue_with_key_delete_top.sv */
// ----------------------------------------------------------------------------
// queue_with_key_delete_top
// ordered queue of signed words with append, remove head, remove tail and
// remove first match of a key, built as a row of shifting cells
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)                tuser
//  req      in         value[31:0]                       operation[1:0]
//  rsp      out        removed_value[31:0], occupancy    status[1:0]
//
//  one item at a time: the transfer cycle marks the cells, the apply cycle
//  runs the found flag along the cell row and shifts or loads in place
//  a result waits in an output register; the apply cycle holds while it
//  is not taken
//  reset is synchronous; it clears the count, the slot valid bits and both
//  handshakes, slot words are left as they are
// ----------------------------------------------------------------------------
`include "queue_with_key_delete_top_macros.svh"

module queue_with_key_delete_top #(
   parameter int CAPACITY   = qwkd_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = qwkd_pkg::DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // removed_value[31:0], occupancy[36:32], zero pad
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import qwkd_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_APPLY = 2'b10
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   op_type                  op_ff;
   op_type                  op_in;
   logic [DATA_WIDTH-1:0]   word_ff;
   logic [DATA_WIDTH-1:0]   word_in;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   status_type              status_ff;
   status_type              status_in;
   logic [IN_WIDTH-1:0]     removed_ff;
   logic [IN_WIDTH-1:0]     removed_in;
   logic [OCC_WIDTH-1:0]    occ_ff;
   logic [OCC_WIDTH-1:0]    occ_in;

   logic                    accept;
   logic                    go;
   logic [DATA_WIDTH-1:0]   req_word;
   cell_ctl_type            ctl;
   logic [DATA_WIDTH-1:0]   cell_word;
   logic [CAPACITY-1:0]     valid_v;
   logic [DATA_WIDTH-1:0]   data_v  [CAPACITY];
   logic [DATA_WIDTH-1:0]   pick_v  [CAPACITY];
   logic [CAPACITY:0]       found_v;
   logic [DATA_WIDTH-1:0]   pick_or;
   logic                    hit;

   assign req_tready = (state_ff == S_IDLE) & ~reset;
   assign accept     = req_tvalid & req_tready;
   assign go         = (state_ff == S_APPLY) & (~rsp_valid_ff | rsp_tready);
   assign req_word   = DATA_WIDTH'($signed(req_tdata));

   assign ctl.mark  = accept;
   assign ctl.apply = go;
   assign ctl.op    = (state_ff == S_IDLE) ? op_type'(req_tuser) : op_ff;
   assign cell_word = (state_ff == S_IDLE) ? req_word : word_ff;

   assign found_v[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  prev_v;
      logic                  next_v;
      logic [DATA_WIDTH-1:0] next_d;
      if (i == 0) begin : g_head
         assign prev_v = 1'b1;
      end else begin : g_mid
         assign prev_v = valid_v[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_v = 1'b0;
         assign next_d = '0;
      end else begin : g_next
         assign next_v = valid_v[i+1];
         assign next_d = data_v[i+1];
      end
      qwkd_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .word       (cell_word),
         .prev_valid (prev_v),
         .found_in   (found_v[i]),
         .next_valid (next_v),
         .next_data  (next_d),
         .valid      (valid_v[i]),
         .data       (data_v[i]),
         .found_out  (found_v[i+1]),
         .pick       (pick_v[i])
      );
   end

   assign hit = found_v[CAPACITY];

   always_comb begin
      pick_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pick_or = pick_or | pick_v[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      word_in      = word_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      status_in    = status_ff;
      removed_in   = removed_ff;
      occ_in       = occ_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_tuser);
               word_in  = req_word;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (go) begin
               removed_in = '0;
               if (op_ff == OP_APPEND) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = STS_FULL;
                  end else begin
                     status_in = STS_OK;
                     count_in  = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  status_in = STS_EMPTY;
               end else if (hit) begin
                  status_in  = STS_OK;
                  removed_in = IN_WIDTH'(pick_or);
                  count_in   = count_ff - CW'(1);
               end else begin
                  status_in = STS_NOTFOUND;
               end
               occ_in       = OCC_WIDTH'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      word_ff    <= word_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      occ_ff     <= occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, occ_ff, removed_ff};

   `QWKD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count overflow")
   `QWKD_ASSERT_NOW(a_ones, clock, reset, 1'b1, $countones(valid_v) == int'(count_ff), "valid bits")
   `QWKD_ASSERT_NEXT(a_one_item, clock, reset, accept, !req_tready, "input not held off")

endmodule
